// ===== src/rti_pkg.sv =====
`default_nettype none
package rti_pkg;

  // Coordinate format (signed fixed point)
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int FIELD_W    = 3 * COORD_BITS;
  localparam int IN_W       = 5 * FIELD_W;

  // Input field slots in the word
  localparam int F_ORIGIN = 0;
  localparam int F_DIR    = 1;
  localparam int F_VA     = 2;
  localparam int F_VB     = 3;
  localparam int F_VC     = 4;

  // Datapath widths
  localparam int EW  = COORD_BITS + 1;  // edges and offsets
  localparam int CPW = 2 * EW;          // cross product terms
  localparam int CW  = CPW + 1;         // cross products
  localparam int DPW = EW + CW;         // dot product terms
  localparam int DW  = DPW + 2;         // dot products
  localparam int NW  = CW;              // normal components

  // Hit distance format and divider
  localparam int T_FRAC  = 16;
  localparam int DIST_W  = 32;
  localparam int QW      = DIST_W - 1;
  localparam int RW      = DW + QW;
  localparam int OUT_RAW = DIST_W + 3 * NW;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  // Configuration
  localparam int DMIN_W          = 20;
  localparam int CFG_DW          = 32;
  localparam int CFG_AW          = 3;
  localparam logic REG_DET_MIN   = 1'b0;
  localparam logic [DMIN_W-1:0] DET_MIN_RST = DMIN_W'(1);

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic                 hit;
    logic signed [DW-1:0] tn;
    logic [DW-1:0]        det;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [NW-1:0] nz;
  } rti_job_t;

endpackage
`default_nettype wire

// ===== src/rti_front.sv =====
`default_nettype none
module rti_front import rti_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_W-1:0]   in_data,
  input  logic [DMIN_W-1:0] det_min,
  input  logic              q_full,
  output logic              job_valid,
  output rti_job_t          job
);

  function automatic logic signed [COORD_BITS-1:0] crd(input logic [IN_W-1:0] d,
                                                       input int f, input int i);
    crd = $signed(d[f*FIELD_W + i*COORD_BITS +: COORD_BITS]);
  endfunction

  logic adv;
  logic [4:0] v_r;
  logic       jv_r;

  // stage 1: edges and offset
  logic signed [EW-1:0]         e1_1_r [3], e2_1_r [3], s_1_r [3];
  logic signed [COORD_BITS-1:0] d_1_r  [3];
  // stage 2: cross product terms
  logic signed [CPW-1:0]        pa_r [3], pb_r [3], na_r [3], nb_r [3], qa_r [3], qb_r [3];
  logic signed [EW-1:0]         e1_2_r [3], e2_2_r [3], s_2_r [3];
  logic signed [COORD_BITS-1:0] d_2_r  [3];
  // stage 3: cross products
  logic signed [CW-1:0]         p_r [3], q_r [3], n_3_r [3];
  logic signed [EW-1:0]         e1_3_r [3], e2_3_r [3], s_3_r [3];
  logic signed [COORD_BITS-1:0] d_3_r  [3];
  // stage 4: dot product terms
  logic signed [DPW-1:0]        dm_r [3], um_r [3], vm_r [3], tm_r [3];
  logic signed [CW-1:0]         n_4_r [3];
  // stage 5: dot products
  logic signed [DW-1:0]         det_r, un_r, vn_r, tn_r;
  logic signed [CW-1:0]         n_5_r [3];

  rti_job_t job_r, job_nxt;

  // whole front moves together; stalls only when its last word cannot enter the queue
  assign adv      = !jv_r || !q_full;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      jv_r <= 1'b0;
    end else if (adv) begin
      v_r  <= {v_r[3:0], in_valid};
      jv_r <= v_r[4];
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    int j, k;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        j = (i == 2) ? 0 : i + 1;
        k = (i == 0) ? 2 : i - 1;
        e1_1_r[i] <= EW'(crd(in_data, F_VB, i)) - EW'(crd(in_data, F_VA, i));
        e2_1_r[i] <= EW'(crd(in_data, F_VC, i)) - EW'(crd(in_data, F_VA, i));
        s_1_r[i]  <= EW'(crd(in_data, F_ORIGIN, i)) - EW'(crd(in_data, F_VA, i));
        d_1_r[i]  <= crd(in_data, F_DIR, i);

        pa_r[i] <= CPW'(d_1_r[j]) * CPW'(e2_1_r[k]);
        pb_r[i] <= CPW'(d_1_r[k]) * CPW'(e2_1_r[j]);
        na_r[i] <= CPW'(e1_1_r[j]) * CPW'(e2_1_r[k]);
        nb_r[i] <= CPW'(e1_1_r[k]) * CPW'(e2_1_r[j]);
        qa_r[i] <= CPW'(s_1_r[j]) * CPW'(e1_1_r[k]);
        qb_r[i] <= CPW'(s_1_r[k]) * CPW'(e1_1_r[j]);
        e1_2_r[i] <= e1_1_r[i];
        e2_2_r[i] <= e2_1_r[i];
        s_2_r[i]  <= s_1_r[i];
        d_2_r[i]  <= d_1_r[i];

        p_r[i]   <= CW'(pa_r[i]) - CW'(pb_r[i]);
        n_3_r[i] <= CW'(na_r[i]) - CW'(nb_r[i]);
        q_r[i]   <= CW'(qa_r[i]) - CW'(qb_r[i]);
        e1_3_r[i] <= e1_2_r[i];
        e2_3_r[i] <= e2_2_r[i];
        s_3_r[i]  <= s_2_r[i];
        d_3_r[i]  <= d_2_r[i];

        dm_r[i]  <= DPW'(e1_3_r[i]) * DPW'(p_r[i]);
        um_r[i]  <= DPW'(s_3_r[i]) * DPW'(p_r[i]);
        vm_r[i]  <= DPW'(d_3_r[i]) * DPW'(q_r[i]);
        tm_r[i]  <= DPW'(e2_3_r[i]) * DPW'(q_r[i]);
        n_4_r[i] <= n_3_r[i];
        n_5_r[i] <= n_4_r[i];
      end
      det_r <= DW'(dm_r[0]) + DW'(dm_r[1]) + DW'(dm_r[2]);
      un_r  <= DW'(um_r[0]) + DW'(um_r[1]) + DW'(um_r[2]);
      vn_r  <= DW'(vm_r[0]) + DW'(vm_r[1]) + DW'(vm_r[2]);
      tn_r  <= DW'(tm_r[0]) + DW'(tm_r[1]) + DW'(tm_r[2]);
      job_r <= job_nxt;
    end
  end

  // classify: front face, determinant floor, barycentric bounds
  always_comb begin
    logic signed [DW-1:0] thr;
    logic signed [DW:0]   uv;
    thr = $signed(DW'(det_min) << FRAC_BITS);
    uv  = (DW+1)'(un_r) + (DW+1)'(vn_r);
    job_nxt.hit = (det_r > 0) && (det_r >= thr) && (un_r >= 0) && (un_r <= det_r) &&
                  (vn_r >= 0) && (uv <= (DW+1)'(det_r));
    job_nxt.tn  = tn_r;
    job_nxt.det = det_r;
    job_nxt.nx  = n_5_r[0];
    job_nxt.ny  = n_5_r[1];
    job_nxt.nz  = n_5_r[2];
  end

  assign job_valid = jv_r;
  assign job       = job_r;

endmodule
`default_nettype wire

// ===== src/rti_queue.sv =====
`default_nettype none
module rti_queue import rti_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  input  rti_job_t push_job,
  output logic     full,
  output logic     pop_valid,
  input  logic     pop_ready,
  output rti_job_t pop_job
);

  rti_job_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     cnt_r;
  logic                push, pop;

  assign full      = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_ready;
  assign pop_job   = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule
`default_nettype wire

// ===== src/rti_back.sv =====
`default_nettype none
module rti_back import rti_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  rti_job_t         job,
  output logic             job_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_hit,
  output logic [OUT_W-1:0] out_data
);

  typedef struct packed {
    logic                 hit;
    logic                 neg;
    logic                 sat;
    logic [DW-1:0]        den;
    logic [RW-1:0]        rem;
    logic [QW-1:0]        quo;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [NW-1:0] nz;
  } rti_div_t;

  logic     adv;
  logic     v_r [QW+1];
  rti_div_t st_r [QW+1];
  rti_div_t st_nxt [QW+1];
  logic     out_v_r;
  logic     out_hit_r;
  logic signed [DIST_W-1:0] dist_r, dist_nxt;
  logic signed [NW-1:0]     nx_r, ny_r, nz_r;

  assign adv     = !out_v_r || out_ready;
  assign job_pop = job_valid && adv;

  // entry: sign, magnitude, saturation test; then one quotient bit per stage
  always_comb begin
    logic [DW-1:0] mag;
    logic [RW-1:0] sh;
    mag = job.tn[DW-1] ? DW'(-job.tn) : DW'(job.tn);
    st_nxt[0].hit = job.hit;
    st_nxt[0].neg = job.tn[DW-1];
    st_nxt[0].sat = (RW'(mag) >= (RW'(job.det) << (QW - T_FRAC)));
    st_nxt[0].den = job.det;
    st_nxt[0].rem = RW'(mag) << T_FRAC;
    st_nxt[0].quo = '0;
    st_nxt[0].nx  = job.nx;
    st_nxt[0].ny  = job.ny;
    st_nxt[0].nz  = job.nz;
    for (int g = 0; g < QW; g++) begin
      sh = RW'(st_r[g].den) << (QW - 1 - g);
      st_nxt[g+1] = st_r[g];
      if (st_r[g].rem >= sh) begin
        st_nxt[g+1].rem = st_r[g].rem - sh;
        st_nxt[g+1].quo[QW-1-g] = 1'b1;
      end
    end
  end

  // valid bits of the divider pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g <= QW; g++) v_r[g] <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v_r[0] <= job_valid;
      for (int g = 0; g < QW; g++) v_r[g+1] <= v_r[g];
      out_v_r <= v_r[QW];
    end
  end

  // divider payload and result register
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g <= QW; g++) st_r[g] <= st_nxt[g];
      out_hit_r <= st_r[QW].hit;
      dist_r    <= dist_nxt;
      nx_r      <= st_r[QW].hit ? st_r[QW].nx : '0;
      ny_r      <= st_r[QW].hit ? st_r[QW].ny : '0;
      nz_r      <= st_r[QW].hit ? st_r[QW].nz : '0;
    end
  end

  // sign and saturation of t; zero on a miss
  always_comb begin
    logic signed [DIST_W-1:0] q;
    q = $signed({1'b0, st_r[QW].quo});
    if (!st_r[QW].hit)
      dist_nxt = '0;
    else if (st_r[QW].sat)
      dist_nxt = st_r[QW].neg ? $signed({1'b1, {QW{1'b0}}}) : $signed({1'b0, {QW{1'b1}}});
    else
      dist_nxt = st_r[QW].neg ? -q : q;
  end

  assign out_valid = out_v_r;
  assign out_hit   = out_hit_r;
  assign out_data  = OUT_W'({nz_r, ny_r, nx_r, dist_r});

endmodule
`default_nettype wire

// ===== src/ray_triangle_intersect.sv =====
`default_nettype none
// Channel   Dir  Width      Contents
// in_       in   240        origin, direction, vertex a, b, c (48 bits each)
// out_      out  144 + 1    tdata: distance, normal x/y/z; tuser: hit
// cfg_      in   32 (APB)   det_min at byte address 0
//
// One word per cycle in and out while no stall holds the flow. The path runs
// through six front stages, the queue, then 33 stages of the distance divider
// (entry, 31 quotient bits one per stage, result register).
// Reset (synchronous, rst_n low) empties every stage and the queue; det_min -> 1.
// A stall on out_tready holds the back end; the front keeps taking words until
// the four-entry queue fills, then in_tready drops.
module ray_triangle_intersect import rti_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,    // ray_origin, ray_dir, vertex_a, vertex_b, vertex_c
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,   // hit_distance, normal_x, normal_y, normal_z, pad
  output logic              out_tuser,   // hit
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [DMIN_W-1:0] det_min_r;
  logic              wr_en;
  logic              q_full, jv, pop_v, pop;
  rti_job_t          job_in, job_out;

  // configuration register
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_DET_MIN);
  assign cfg_prdata = (cfg_paddr[2] == REG_DET_MIN) ? CFG_DW'(det_min_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) det_min_r <= DET_MIN_RST;
    else if (wr_en) det_min_r <= cfg_pwdata[DMIN_W-1:0];
  end

  rti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .det_min   (det_min_r),
    .q_full    (q_full),
    .job_valid (jv),
    .job       (job_in)
  );

  rti_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (jv),
    .push_job   (job_in),
    .full       (q_full),
    .pop_valid  (pop_v),
    .pop_ready  (pop),
    .pop_job    (job_out)
  );

  rti_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_v),
    .job       (job_out),
    .job_pop   (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_hit   (out_tuser),
    .out_data  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== src/rti_checker.sv =====
`default_nettype none
module rti_checker import rti_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [IN_W-1:0]   in_tdata,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata,
  input logic              out_tuser,
  input logic              cfg_psel,
  input logic              cfg_penable,
  input logic              cfg_pwrite,
  input logic [CFG_AW-1:0] cfg_paddr,
  input logic [CFG_DW-1:0] cfg_pwdata,
  input logic [CFG_DW-1:0] cfg_prdata,
  input logic              cfg_pready
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed under stall");

  // a miss carries all-zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss with nonzero payload");

  // a front-face hit has a positive determinant, so the normal cannot vanish
  a_hit_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[OUT_RAW-1:DIST_W] != '0)
    else $error("hit with zero normal");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);
`default_nettype wire
